// ----- hdl/gvt4_pkg.sv -----
// ----------------------------------------------------------------------------
// gvt4_pkg
// Shared types, register map, reset values and saturating helpers for the
// GVT4 enhancement evaluator. Internal math is signed Q31.32 (64 bits).
// ----------------------------------------------------------------------------
package gvt4_pkg;

	localparam int WORK_FRAC     = 32;
	localparam int FRAC_BITS_DEF = 24;
	localparam int ADDR_W        = 5;
	// reciprocal: restoring divide of 2^65 by gamma, two quotient bits per stage
	localparam int RCP_BITS   = 66;
	localparam int RCP_STEP   = 2;
	localparam int RCP_STAGES = RCP_BITS / RCP_STEP;

	typedef logic signed [63:0] w64_t;
	typedef logic signed [65:0] w66_t;

	localparam w64_t W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam w64_t W_MIN = 64'sh8000_0000_0000_0000;
	localparam w64_t W_ONE = 64'sh0000_0001_0000_0000;

	typedef enum logic [2:0] {
		REG_COEF_CONST = 3'd0,
		REG_COEF_X2    = 3'd1,
		REG_COEF_Z     = 3'd2,
		REG_COEF_X4    = 3'd3,
		REG_COEF_X2Z   = 3'd4,
		REG_COEF_Z2    = 3'd5,
		REG_ALPHA_GAIN = 3'd6,
		REG_WANT_DERIV = 3'd7
	} reg_idx_t;

	localparam logic signed [31:0] RST_COEF_CONST = -32'sd1052266988;
	localparam logic signed [31:0] RST_COEF_X2    = -32'sd3819300;
	localparam logic signed [31:0] RST_COEF_Z     = 32'sd6710886;
	localparam logic signed [31:0] RST_COEF_X4    = -32'sd25276;
	localparam logic signed [31:0] RST_COEF_X2Z   = -32'sd137761;
	localparam logic signed [31:0] RST_COEF_Z2    = 32'sd383863;
	localparam logic [30:0]        RST_ALPHA_GAIN = 31'd2004676;
	localparam logic               RST_WANT_DERIV = 1'b1;

	typedef struct packed {
		logic [30:0]        grad_x;
		logic signed [31:0] kin_z;
	} item_t;

	typedef struct packed {
		logic signed [47:0] h_value;
		logic signed [47:0] dh_dx;
		logic signed [47:0] dh_dz;
	} res_t;

	// working set carried down the pipeline
	typedef struct packed {
		w64_t x;
		w64_t z;
		w64_t x2;
		w64_t xz;
		w64_t zz;
		w64_t c1x;
		w64_t ax2;
		w64_t s;
		w64_t gam;
		w64_t x4;
		w64_t x2z;
		w64_t xx2;
		w64_t c4xz;
		w64_t c5zz;
		w64_t n2;
		w64_t tz;
		w64_t n3;
		w64_t tx;
		w64_t r1;
		w64_t r2;
		w64_t r3;
		w64_t r4;
		w64_t h;
		w64_t dg;
		w64_t dg3;
		w64_t dx;
		w64_t dz;
	} wk_t;

	function automatic w64_t sat66(input w66_t v);
		if (v[65:63] == 3'b000 || v[65:63] == 3'b111) begin
			return v[63:0];
		end
		return v[65] ? W_MIN : W_MAX;
	endfunction

	function automatic w64_t sadd(input w64_t a, input w64_t b);
		return sat66(66'(a) + 66'(b));
	endfunction

	function automatic w64_t sc2(input w64_t a);
		return sat66(66'(a) <<< 1);
	endfunction

	function automatic w64_t sc3(input w64_t a);
		return sat66((66'(a) <<< 1) + 66'(a));
	endfunction

	function automatic w64_t sc4(input w64_t a);
		return sat66(66'(a) <<< 2);
	endfunction

	function automatic w64_t negs(input w64_t a);
		return (a == W_MIN) ? W_MAX : -a;
	endfunction

endpackage

// ----- hdl/gvt4_enhancement_eval.sv -----
// ----------------------------------------------------------------------------
// gvt4_enhancement_eval
// GVT4 meta-GGA exchange enhancement h(x, z) with optional dh/dx and dh/dz.
// ----------------------------------------------------------------------------
// Usage:
//   item (grad_x, kin_z) enters on item_valid/item_ready; one result beat
//   (h_value, dh_dx, dh_dz) leaves on res_valid/res_ready per item.
//   One beat can enter every cycle while the output is not stalled; the
//   pipeline holds up to 71 items in flight plus one in the output register.
//   The pipeline is built from seven multiplier phases (four multiplier
//   stages plus a summing stage each) and the 33-stage reciprocal,
//   which retires two quotient bits per stage.
//   The whole pipeline advances when the output register is empty or taken;
//   a stalled receiver freezes every stage and drops item_ready, nothing is
//   lost or repeated.
//   Reset clears all valid bits and loads the coefficient registers with
//   their defaults. The APB port writes registers at byte address 4*index;
//   write only while no item is in flight.
//   With want_derivatives cleared, dh_dx and dh_dz are zero.
// ----------------------------------------------------------------------------
module gvt4_enhancement_eval #(
	parameter int FRAC_BITS = gvt4_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  gvt4_pkg::item_t               item,
	output logic                          res_valid,
	input  logic                          res_ready,
	output gvt4_pkg::res_t                res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gvt4_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import gvt4_pkg::*;

	localparam int   IN_SHIFT = WORK_FRAC - FRAC_BITS;
	localparam w64_t RND_HALF = w64_t'((64'd1 << IN_SHIFT) >> 1);
	localparam w64_t OUT_HI   = 64'sh0000_7FFF_FFFF_FFFF;
	localparam w64_t OUT_LO   = 64'shFFFF_8000_0000_0000;

	function automatic logic signed [47:0] to_out(input w64_t v);
		w64_t r;
		r = sadd(v, RND_HALF) >>> IN_SHIFT;
		if (r > OUT_HI) begin
			return OUT_HI[47:0];
		end
		if (r < OUT_LO) begin
			return OUT_LO[47:0];
		end
		return r[47:0];
	endfunction

	// ---------------- configuration ----------------
	logic signed [31:0] coef_const_q, coef_x2_q, coef_z_q, coef_x4_q, coef_x2z_q, coef_z2_q;
	logic [30:0]        alpha_gain_q;
	logic               want_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_const_q <= RST_COEF_CONST;
			coef_x2_q    <= RST_COEF_X2;
			coef_z_q     <= RST_COEF_Z;
			coef_x4_q    <= RST_COEF_X4;
			coef_x2z_q   <= RST_COEF_X2Z;
			coef_z2_q    <= RST_COEF_Z2;
			alpha_gain_q <= RST_ALPHA_GAIN;
			want_q       <= RST_WANT_DERIV;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COEF_CONST: coef_const_q <= pwdata;
				REG_COEF_X2:    coef_x2_q    <= pwdata;
				REG_COEF_Z:     coef_z_q     <= pwdata;
				REG_COEF_X4:    coef_x4_q    <= pwdata;
				REG_COEF_X2Z:   coef_x2z_q   <= pwdata;
				REG_COEF_Z2:    coef_z2_q    <= pwdata;
				REG_ALPHA_GAIN: alpha_gain_q <= pwdata[30:0];
				REG_WANT_DERIV: want_q       <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_COEF_CONST: prdata = coef_const_q;
			REG_COEF_X2:    prdata = coef_x2_q;
			REG_COEF_Z:     prdata = coef_z_q;
			REG_COEF_X4:    prdata = coef_x4_q;
			REG_COEF_X2Z:   prdata = coef_x2z_q;
			REG_COEF_Z2:    prdata = coef_z2_q;
			REG_ALPHA_GAIN: prdata = {1'b0, alpha_gain_q};
			REG_WANT_DERIV: prdata = {31'd0, want_q};
		endcase
	end

	// coefficients in Q31.32
	w64_t c0, c1, c2, c3, c4, c5, al;
	assign c0 = 64'(coef_const_q) <<< 2;
	assign c1 = 64'(coef_x2_q)    <<< 2;
	assign c2 = 64'(coef_z_q)     <<< 2;
	assign c3 = 64'(coef_x4_q)    <<< 2;
	assign c4 = 64'(coef_x2z_q)   <<< 2;
	assign c5 = 64'(coef_z2_q)    <<< 2;
	assign al = w64_t'({33'd0, alpha_gain_q}) <<< 2;

	// ---------------- pipeline control ----------------
	logic en;
	assign en         = !res_valid || res_ready;
	assign item_ready = en;

	// input capture
	logic vld_s0;
	wk_t  wk_in, wk_s0;

	always_comb begin
		wk_in   = '0;
		wk_in.x = w64_t'({33'd0, item.grad_x}) <<< IN_SHIFT;
		wk_in.z = 64'(item.kin_z) <<< IN_SHIFT;
	end

	// phase 1: x^2, xz, z^2, c1*x, alpha*x
	w64_t b1_a [5], b1_b [5], b1_p [5];
	wk_t  b1_wk, nx_s5, wk_s5;
	logic b1_vld, vld_s5;

	always_comb begin
		b1_a = '{wk_s0.x, wk_s0.x, wk_s0.z, c1, al};
		b1_b = '{wk_s0.x, wk_s0.z, wk_s0.z, wk_s0.x, wk_s0.x};
	end

	gvt4_mulbank #(.NMUL(5)) u_bank1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s0),
		.a(b1_a), .b(b1_b), .wk_i(wk_s0), .vld_o(b1_vld), .p(b1_p), .wk_o(b1_wk)
	);

	always_comb begin
		nx_s5     = b1_wk;
		nx_s5.x2  = b1_p[0];
		nx_s5.xz  = b1_p[1];
		nx_s5.zz  = b1_p[2];
		nx_s5.c1x = b1_p[3];
		nx_s5.ax2 = sc2(b1_p[4]);
		nx_s5.s   = sadd(b1_p[0], b1_wk.z);
	end

	// phase 2: gamma, x^4, x^2 z, n2 terms, derivative terms
	w64_t b2_a [10], b2_b [10], b2_p [10];
	wk_t  b2_wk, nx_s10, wk_s10;
	logic b2_vld, vld_s10;

	always_comb begin
		b2_a = '{al, wk_s5.x2, wk_s5.x2, c1, c2, wk_s5.x, c4, c5, c4, c5};
		b2_b = '{wk_s5.s, wk_s5.x2, wk_s5.z, wk_s5.x2, wk_s5.z, wk_s5.x2,
			wk_s5.x2, wk_s5.z, wk_s5.xz, wk_s5.zz};
	end

	gvt4_mulbank #(.NMUL(10)) u_bank2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s5),
		.a(b2_a), .b(b2_b), .wk_i(wk_s5), .vld_o(b2_vld), .p(b2_p), .wk_o(b2_wk)
	);

	always_comb begin
		nx_s10      = b2_wk;
		nx_s10.gam  = sadd(W_ONE, b2_p[0]);
		nx_s10.x4   = b2_p[1];
		nx_s10.x2z  = b2_p[2];
		nx_s10.n2   = sadd(b2_p[3], b2_p[4]);
		nx_s10.xx2  = b2_p[5];
		nx_s10.tz   = sadd(b2_p[6], sc2(b2_p[7]));
		nx_s10.c4xz = b2_p[8];
		nx_s10.c5zz = b2_p[9];
	end

	// phase 3: n3 and the x-derivative numerator
	w64_t b3_a [3], b3_b [3], b3_p [3];
	wk_t  b3_wk, nx_s15, wk_s15;
	logic b3_vld, vld_s15;

	always_comb begin
		b3_a = '{c3, c4, c3};
		b3_b = '{wk_s10.x4, wk_s10.x2z, wk_s10.xx2};
	end

	gvt4_mulbank #(.NMUL(3)) u_bank3 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s10),
		.a(b3_a), .b(b3_b), .wk_i(wk_s10), .vld_o(b3_vld), .p(b3_p), .wk_o(b3_wk)
	);

	always_comb begin
		nx_s15    = b3_wk;
		nx_s15.n3 = sadd(sadd(b3_p[0], b3_p[1]), b3_wk.c5zz);
		nx_s15.tx = sadd(sc4(b3_p[2]), sc2(b3_wk.c4xz));
	end

	// reciprocal: floor(2^65 / gamma), rounded to 2^64 / gamma afterwards
	logic [63:0]          rcp_rem_s [RCP_STAGES];
	logic [RCP_BITS-1:0]  rcp_quo_s [RCP_STAGES];
	wk_t                  rcp_wk_s  [RCP_STAGES];
	logic [RCP_STAGES-1:0] rcp_vld;

	for (genvar k = 0; k < RCP_STAGES; k++) begin : g_rcp
		logic [63:0]         rem_in, rem_nx;
		logic [RCP_BITS-1:0] quo_in, quo_nx;
		wk_t                 wk_rin;
		logic                v_in;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign wk_rin = wk_s15;
			assign v_in   = vld_s15;
		end else begin : g_next
			assign rem_in = rcp_rem_s[k-1];
			assign quo_in = rcp_quo_s[k-1];
			assign wk_rin = rcp_wk_s[k-1];
			assign v_in   = rcp_vld[k-1];
		end

		always_comb begin
			logic [64:0] r;
			logic        qb;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int j = 0; j < RCP_STEP; j++) begin
				// the dividend has a single set bit, the first one shifted in
				r  = {rem_nx, (k == 0 && j == 0)};
				qb = (r >= {1'b0, wk_rin.gam});
				if (qb) begin
					r = r - {1'b0, wk_rin.gam};
				end
				rem_nx = r[63:0];
				quo_nx = {quo_nx[RCP_BITS-2:0], qb};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rcp_vld[k] <= 1'b0;
			end else if (en) begin
				rcp_vld[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rcp_rem_s[k] <= rem_nx;
				rcp_quo_s[k] <= quo_nx;
				rcp_wk_s[k]  <= wk_rin;
			end
		end
	end

	wk_t               nx_s49, wk_s49;
	logic              vld_s49;
	logic [RCP_BITS:0] qsum;

	always_comb begin
		nx_s49 = rcp_wk_s[RCP_STAGES-1];
		qsum   = {1'b0, rcp_quo_s[RCP_STAGES-1]} + 1'b1;
		// gamma at or below one LSB saturates the reciprocal
		if (nx_s49.gam <= 64'sd1 || qsum[RCP_BITS:1] > 66'h7FFF_FFFF_FFFF_FFFF) begin
			nx_s49.r1 = W_MAX;
		end else begin
			nx_s49.r1 = qsum[64:1];
		end
	end

	// phase 4: r^2, n1 r
	w64_t b4_a [2], b4_b [2], b4_p [2];
	wk_t  b4_wk, nx_s54, wk_s54;
	logic b4_vld, vld_s54;

	always_comb begin
		b4_a = '{wk_s49.r1, c0};
		b4_b = '{wk_s49.r1, wk_s49.r1};
	end

	gvt4_mulbank #(.NMUL(2)) u_bank4 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s49),
		.a(b4_a), .b(b4_b), .wk_i(wk_s49), .vld_o(b4_vld), .p(b4_p), .wk_o(b4_wk)
	);

	always_comb begin
		nx_s54    = b4_wk;
		nx_s54.r2 = b4_p[0];
		nx_s54.h  = b4_p[1];
	end

	// phase 5: r^3, r^4 and the r^2 terms
	w64_t b5_a [6], b5_b [6], b5_p [6];
	wk_t  b5_wk, nx_s59, wk_s59;
	logic b5_vld, vld_s59;

	always_comb begin
		b5_a = '{wk_s54.r2, wk_s54.r2, wk_s54.n2, c0, wk_s54.c1x, c2};
		b5_b = '{wk_s54.r1, wk_s54.r2, wk_s54.r2, wk_s54.r2, wk_s54.r2, wk_s54.r2};
	end

	gvt4_mulbank #(.NMUL(6)) u_bank5 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s54),
		.a(b5_a), .b(b5_b), .wk_i(wk_s54), .vld_o(b5_vld), .p(b5_p), .wk_o(b5_wk)
	);

	always_comb begin
		nx_s59    = b5_wk;
		nx_s59.r3 = b5_p[0];
		nx_s59.r4 = b5_p[1];
		nx_s59.h  = sadd(b5_wk.h, b5_p[2]);
		nx_s59.dg = b5_p[3];
		nx_s59.dx = sc2(b5_p[4]);
		nx_s59.dz = b5_p[5];
	end

	// phase 6: r^3 and r^4 terms
	w64_t b6_a [5], b6_b [5], b6_p [5];
	wk_t  b6_wk, nx_s64, wk_s64;
	logic b6_vld, vld_s64;

	always_comb begin
		b6_a = '{wk_s59.n3, wk_s59.n2, wk_s59.n3, wk_s59.tx, wk_s59.tz};
		b6_b = '{wk_s59.r3, wk_s59.r3, wk_s59.r4, wk_s59.r3, wk_s59.r3};
	end

	gvt4_mulbank #(.NMUL(5)) u_bank6 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s59),
		.a(b6_a), .b(b6_b), .wk_i(wk_s59), .vld_o(b6_vld), .p(b6_p), .wk_o(b6_wk)
	);

	always_comb begin
		nx_s64     = b6_wk;
		nx_s64.h   = sadd(b6_wk.h, b6_p[0]);
		nx_s64.dg  = sadd(b6_wk.dg, sc2(b6_p[1]));
		nx_s64.dg3 = sc3(b6_p[2]);
		nx_s64.dx  = sadd(b6_wk.dx, b6_p[3]);
		nx_s64.dz  = sadd(b6_wk.dz, b6_p[4]);
	end

	// dh/dgamma, negated
	wk_t  nx_s65, wk_s65;
	logic vld_s65;

	always_comb begin
		nx_s65    = wk_s64;
		nx_s65.dg = negs(sadd(wk_s64.dg, wk_s64.dg3));
	end

	// phase 8: chain rule through gamma
	w64_t b8_a [2], b8_b [2], b8_p [2];
	wk_t  b8_wk, nx_s70, wk_s70;
	logic b8_vld, vld_s70;

	always_comb begin
		b8_a = '{wk_s65.dg, wk_s65.dg};
		b8_b = '{wk_s65.ax2, al};
	end

	gvt4_mulbank #(.NMUL(2)) u_bank8 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s65),
		.a(b8_a), .b(b8_b), .wk_i(wk_s65), .vld_o(b8_vld), .p(b8_p), .wk_o(b8_wk)
	);

	always_comb begin
		nx_s70    = b8_wk;
		nx_s70.dx = sadd(b8_wk.dx, b8_p[0]);
		nx_s70.dz = sadd(b8_wk.dz, b8_p[1]);
	end

	// ---------------- stage registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s10   <= 1'b0;
			vld_s15   <= 1'b0;
			vld_s49   <= 1'b0;
			vld_s54   <= 1'b0;
			vld_s59   <= 1'b0;
			vld_s64   <= 1'b0;
			vld_s65   <= 1'b0;
			vld_s70   <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			vld_s0    <= item_valid;
			vld_s5    <= b1_vld;
			vld_s10   <= b2_vld;
			vld_s15   <= b3_vld;
			vld_s49   <= rcp_vld[RCP_STAGES-1];
			vld_s54   <= b4_vld;
			vld_s59   <= b5_vld;
			vld_s64   <= b6_vld;
			vld_s65   <= vld_s64;
			vld_s70   <= b8_vld;
			res_valid <= vld_s70;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wk_s0       <= wk_in;
			wk_s5       <= nx_s5;
			wk_s10      <= nx_s10;
			wk_s15      <= nx_s15;
			wk_s49      <= nx_s49;
			wk_s54      <= nx_s54;
			wk_s59      <= nx_s59;
			wk_s64      <= nx_s64;
			wk_s65      <= nx_s65;
			wk_s70      <= nx_s70;
			res.h_value <= to_out(wk_s70.h);
			res.dh_dx   <= want_q ? to_out(wk_s70.dx) : '0;
			res.dh_dz   <= want_q ? to_out(wk_s70.dz) : '0;
		end
	end

`ifndef SYNTH
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> vld_s0)
		else $error("accepted beat did not enter the pipeline");

	a_rcp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rcp_vld))
		else $error("divider stages moved during a stall");

	a_no_deriv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !want_q |-> res.dh_dx == '0 && res.dh_dz == '0)
		else $error("derivatives nonzero while disabled");
`endif

endmodule

// ----- hdl/gvt4_mulbank.sv -----
// ----------------------------------------------------------------------------
// gvt4_mulbank
// NMUL parallel Q31.32 multipliers, four stages each, with the working set
// delayed alongside. Products round half away from zero and saturate.
// ----------------------------------------------------------------------------
module gvt4_mulbank #(
	parameter int NMUL = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  gvt4_pkg::w64_t a [NMUL],
	input  gvt4_pkg::w64_t b [NMUL],
	input  gvt4_pkg::wk_t  wk_i,
	output logic           vld_o,
	output gvt4_pkg::w64_t p [NMUL],
	output gvt4_pkg::wk_t  wk_o
);
	import gvt4_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	wk_t  wk_s1, wk_s2, wk_s3, wk_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wk_s1 <= wk_i;
			wk_s2 <= wk_s1;
			wk_s3 <= wk_s2;
			wk_s4 <= wk_s3;
		end
	end

	assign vld_o = vld_s4;
	assign wk_o  = wk_s4;

	for (genvar i = 0; i < NMUL; i++) begin : g_lane
		logic          neg_s1, neg_s2, neg_s3;
		logic [63:0]   ma_s1, mb_s1;
		logic [63:0]   ll_s2, lh_s2, hl_s2, hh_s2;
		logic [127:0]  pr_s3;
		w64_t          p_s4;
		logic [63:0]   ma, mb;
		logic [127:0]  rs;
		logic [95:0]   m;
		w64_t          pq;

		assign ma = a[i][63] ? (~a[i] + 64'd1) : a[i];
		assign mb = b[i][63] ? (~b[i] + 64'd1) : b[i];

		// round on the magnitude, then restore the sign
		always_comb begin
			rs = pr_s3 + 128'h8000_0000;
			m  = rs[127:32];
			if (!neg_s3) begin
				pq = (m > 96'h7FFF_FFFF_FFFF_FFFF) ? W_MAX : w64_t'(m[63:0]);
			end else begin
				pq = (m > 96'h8000_0000_0000_0000) ? W_MIN : w64_t'(~m[63:0] + 64'd1);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1 <= a[i][63] ^ b[i][63];
				ma_s1  <= ma;
				mb_s1  <= mb;
				neg_s2 <= neg_s1;
				ll_s2  <= ma_s1[31:0]  * mb_s1[31:0];
				lh_s2  <= ma_s1[31:0]  * mb_s1[63:32];
				hl_s2  <= ma_s1[63:32] * mb_s1[31:0];
				hh_s2  <= ma_s1[63:32] * mb_s1[63:32];
				neg_s3 <= neg_s2;
				pr_s3  <= {hh_s2, 64'd0} + {32'd0, lh_s2, 32'd0} + {32'd0, hl_s2, 32'd0}
					+ {64'd0, ll_s2};
				p_s4   <= pq;
			end
		end

		assign p[i] = p_s4;
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gvt4_enhancement_eval. Items stream in on a
// valid/ready channel with random gaps. A bit-exact fixed-point predictor
// computes h, dh/dx and dh/dz for each accepted item, and every result beat
// is compared with the oldest prediction. Coefficients are rewritten over
// APB between drained phases: reset values, random values and the extremes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gvt4_pkg::*;

	localparam int IN_SH    = 32 - FRAC_BITS_DEF;
	localparam int WD_LIMIT = 4000;

	logic clk, arst_n;
	logic item_valid, item_ready, res_valid, res_ready;
	item_t item;
	res_t res;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	gvt4_enhancement_eval u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow copy of the coefficient registers
	w64_t k_const, k_x2, k_z, k_x4, k_x2z, k_z2, k_alpha;
	logic k_deriv;

	item_t pend_q[$];
	res_t  enh_q[$];
	int    errors;
	logic  hold_send, no_gaps;
	logic  in_took;
	int    quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic w64_t add_sat(w64_t a, w64_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? W_MIN : W_MAX;
		return s[63:0];
	endfunction

	function automatic w64_t times_sat(w64_t a, int k);
		w64_t r;
		r = '0;
		for (int i = 0; i < k; i++) r = add_sat(r, a);
		return r;
	endfunction

	// Q31.32 product, rounded half away from zero, saturated
	function automatic w64_t qmul(w64_t a, w64_t b);
		logic neg;
		logic [63:0] ma, mb;
		logic [127:0] p;
		neg = a[63] ^ b[63];
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		p = {64'b0, ma} * {64'b0, mb};
		p = (p + (128'd1 << 31)) >> 32;
		if (!neg) return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? W_MAX : w64_t'(p[63:0]);
		if (p > 128'h8000_0000_0000_0000) return W_MIN;
		return -w64_t'(p[63:0]);
	endfunction

	function automatic w64_t inv_gamma(w64_t g);
		logic [65:0] q, rem;
		if (g <= 64'sd1) return W_MAX;
		q = (66'd1 << 64) / 66'(g);
		rem = (66'd1 << 64) % 66'(g);
		if ((rem << 1) >= 66'(g)) q = q + 1;
		if (q > 66'h7FFF_FFFF_FFFF_FFFF) return W_MAX;
		return q[63:0];
	endfunction

	function automatic logic signed [47:0] out_q(w64_t v);
		w64_t r;
		r = add_sat(v, w64_t'(1) <<< (IN_SH - 1)) >>> IN_SH;
		if (r > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		if (r < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
		return r[47:0];
	endfunction

	function automatic res_t enhancement(item_t it);
		w64_t x, z, c0, c1, c2, c3, c4, c5, al, x2, gam, r1, r2, r3, r4;
		w64_t n2, n3, h, dg, t, dx, dz;
		res_t o;
		x = w64_t'({33'b0, it.grad_x}) <<< IN_SH;
		z = w64_t'(it.kin_z) <<< IN_SH;
		c0 = k_const <<< 2; c1 = k_x2 <<< 2; c2 = k_z <<< 2;
		c3 = k_x4 <<< 2; c4 = k_x2z <<< 2; c5 = k_z2 <<< 2; al = k_alpha <<< 2;
		x2 = qmul(x, x);
		gam = add_sat(W_ONE, qmul(al, add_sat(x2, z)));
		r1 = inv_gamma(gam);
		r2 = qmul(r1, r1);
		r3 = qmul(r2, r1);
		r4 = qmul(r2, r2);
		n2 = add_sat(qmul(c1, x2), qmul(c2, z));
		n3 = add_sat(add_sat(qmul(c3, qmul(x2, x2)), qmul(c4, qmul(x2, z))),
			qmul(c5, qmul(z, z)));
		h = add_sat(add_sat(qmul(c0, r1), qmul(n2, r2)), qmul(n3, r3));
		o.h_value = out_q(h);
		o.dh_dx = '0;
		o.dh_dz = '0;
		if (k_deriv) begin
			dg = add_sat(add_sat(qmul(c0, r2), times_sat(qmul(n2, r3), 2)),
				times_sat(qmul(n3, r4), 3));
			dg = (dg == W_MIN) ? W_MAX : -dg;
			t = add_sat(times_sat(qmul(c3, qmul(x, x2)), 4),
				times_sat(qmul(c4, qmul(x, z)), 2));
			dx = add_sat(add_sat(times_sat(qmul(qmul(c1, x), r2), 2), qmul(t, r3)),
				qmul(dg, times_sat(qmul(al, x), 2)));
			t = add_sat(qmul(c4, x2), times_sat(qmul(c5, z), 2));
			dz = add_sat(add_sat(qmul(c2, r2), qmul(t, r3)), qmul(dg, al));
			o.dh_dx = out_q(dx);
			o.dh_dz = out_q(dz);
		end
		return o;
	endfunction

	// driver: new beat after the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || in_took) begin
			if (pend_q.size() > 0 && !hold_send && (no_gaps || $urandom_range(0, 99) >= 36)) begin
				item <= pend_q.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		res_ready <= no_gaps || ($urandom_range(0, 99) >= 36);
	end

	// monitor
	always @(posedge clk) begin
		res_t e;
		in_took <= arst_n && item_valid && item_ready;
		if (arst_n && item_valid && item_ready) enh_q.push_back(enhancement(item));
		if (arst_n && res_valid && res_ready) begin
			if (enh_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = enh_q.pop_front();
				if (res.h_value !== e.h_value) begin
					$error("h_value exp %0d got %0d", e.h_value, res.h_value);
					errors++;
				end
				if (res.dh_dx !== e.dh_dx) begin
					$error("dh_dx exp %0d got %0d", e.dh_dx, res.dh_dx);
					errors++;
				end
				if (res.dh_dz !== e.dh_dz) begin
					$error("dh_dz exp %0d got %0d", e.dh_dz, res.dh_dz);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WD_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = ADDR_W'(idx) << 2; pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
		case (idx)
			REG_COEF_CONST: k_const = w64_t'($signed(v));
			REG_COEF_X2:    k_x2 = w64_t'($signed(v));
			REG_COEF_Z:     k_z = w64_t'($signed(v));
			REG_COEF_X4:    k_x4 = w64_t'($signed(v));
			REG_COEF_X2Z:   k_x2z = w64_t'($signed(v));
			REG_COEF_Z2:    k_z2 = w64_t'($signed(v));
			REG_ALPHA_GAIN: k_alpha = w64_t'({33'b0, v[30:0]});
			REG_WANT_DERIV: k_deriv = v[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pend_q.size() > 0 || item_valid || enh_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic item_t rand_item();
		item_t it;
		if ($urandom_range(0, 9) < 3) begin
			it.grad_x = 31'($urandom);
			it.kin_z = $urandom;
		end else begin
			// physically typical range: x up to 10, z in [-2, 10]
			it.grad_x = 31'($urandom_range(0, 10 << 24));
			it.kin_z = $signed($urandom_range(0, 12 << 24)) - (2 <<< 24);
		end
		return it;
	endfunction

	task automatic send(logic [30:0] gx, logic [31:0] kz);
		item_t it;
		it.grad_x = gx;
		it.kin_z = kz;
		pend_q.push_back(it);
	endtask

	task automatic random_regs(logic ext);
		for (int r = 0; r < 6; r++)
			reg_write(reg_idx_t'(r), ext ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
				: $signed($urandom_range(0, 1 << 26)) - (1 <<< 25));
		reg_write(REG_ALPHA_GAIN, ext ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0)
			: $urandom_range(0, 1 << 24));
		reg_write(REG_WANT_DERIV, $urandom_range(0, 1));
	endtask

	initial begin
		errors = 0;
		hold_send = 1'b0;
		no_gaps = 1'b0;
		item_valid = 1'b0;
		res_ready = 1'b0;
		item = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		k_const = RST_COEF_CONST; k_x2 = RST_COEF_X2; k_z = RST_COEF_Z;
		k_x4 = RST_COEF_X4; k_x2z = RST_COEF_X2Z; k_z2 = RST_COEF_Z2;
		k_alpha = w64_t'({33'b0, RST_ALPHA_GAIN}); k_deriv = RST_WANT_DERIV;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and gamma at or below zero
		send('0, '0);
		send(31'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(31'h7FFF_FFFF, 32'h8000_0000);
		send('0, 32'h8000_0000);
		send('0, 32'h7FFF_FFFF);
		send(31'd1 << 24, 32'hFF00_0000);
		send(31'd1, 32'hFFFF_FFFF);
		send(31'h5555_5555, 32'hAAAA_AAAA);
		send(31'h2AAA_AAAA, 32'h5555_5555);
		drain();
		reg_write(REG_ALPHA_GAIN, 32'h7FFF_FFFF);
		send('0, 32'hFF80_0000);   // gamma near zero
		send('0, 32'hFF00_0000);   // gamma negative
		send(31'd3 << 24, 32'h8000_0000);
		drain();
		reg_write(REG_WANT_DERIV, 32'h0);
		send(31'd2 << 24, 32'd1 << 24);
		send(31'h7FFF_FFFF, 32'h8000_0000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				reg_write(REG_COEF_CONST, RST_COEF_CONST);
				reg_write(REG_COEF_X2, RST_COEF_X2);
				reg_write(REG_COEF_Z, RST_COEF_Z);
				reg_write(REG_COEF_X4, RST_COEF_X4);
				reg_write(REG_COEF_X2Z, RST_COEF_X2Z);
				reg_write(REG_COEF_Z2, RST_COEF_Z2);
				reg_write(REG_ALPHA_GAIN, RST_ALPHA_GAIN);
				reg_write(REG_WANT_DERIV, 32'h1);
			end else begin
				random_regs(ph % 3 == 2);
			end
			no_gaps = (ph == 3);
			for (int i = 0; i < 125; i++) pend_q.push_back(rand_item());
			if (ph == 5) begin
				// pause the sender mid-phase until the pipe is empty
				while (pend_q.size() > 60) @(posedge clk);
				hold_send = 1'b1;
				while (enh_q.size() > 0 || item_valid) @(posedge clk);
				hold_send = 1'b0;
			end
			drain();
		end
		no_gaps = 1'b0;
		repeat (80) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

// ----- gvt4_enhancement_eval.f -----
hdl/gvt4_pkg.sv
hdl/gvt4_mulbank.sv
hdl/gvt4_enhancement_eval.sv
tb/tb.sv
